// ----- design/nearest_site_distance_binner_top_defines.svh -----
// Assertion macros used by the asserting file of the distance binner.
// Define ASSERT_OFF to compile the assertions out.
`ifndef NEAREST_SITE_DISTANCE_BINNER_TOP_DEFINES_SVH
`define NEAREST_SITE_DISTANCE_BINNER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define NSDB_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nsdb assertion failed");
`define NSDB_ASSERT(label, prop) \
    `NSDB_ASSERT_CLK(label, i_clk, i_rst_n, prop)
`else
`define NSDB_ASSERT_CLK(label, clk, rst_n, prop)
`define NSDB_ASSERT(label, prop)
`endif

`endif

// ----- design/nsdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nsdb_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 4096;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned FREQ_W  = 9;
    localparam int unsigned BIN_W   = 9;
    localparam int unsigned FBIN_W  = 3;
    localparam int unsigned DBIN_W  = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int unsigned NUM_THRESH    = 26;
    localparam int unsigned DIST_BIN_SPAN = 27;
    localparam int unsigned PLAT_SPAN     = 135;

    // floor(10^(3.5 + 0.1k)), k = 0..25
    localparam logic [POS_W-1:0] DIST_THRESH [NUM_THRESH] = '{
        32'd3162,   32'd3981,   32'd5011,   32'd6309,   32'd7943,
        32'd10000,  32'd12589,  32'd15848,  32'd19952,  32'd25118,
        32'd31622,  32'd39810,  32'd50118,  32'd63095,  32'd79432,
        32'd100000, 32'd125892, 32'd158489, 32'd199526, 32'd251188,
        32'd316227, 32'd398107, 32'd501187, 32'd630957, 32'd794328,
        32'd1000000
    };

    typedef struct packed {
        logic              valid;
        logic              empty;
        logic [POS_W-1:0]  near_dist;
        logic [FBIN_W-1:0] fbin;
        logic              plat;
    } t_search_res;

    // Frequency in thousandths to a bin of 100; everything from 400 up is the top bin.
    function automatic logic [FBIN_W-1:0] freq_bin(input logic [FREQ_W-1:0] f);
        logic [FBIN_W-1:0] b;
        if (f >= FREQ_W'(400))      b = FBIN_W'(4);
        else if (f >= FREQ_W'(300)) b = FBIN_W'(3);
        else if (f >= FREQ_W'(200)) b = FBIN_W'(2);
        else if (f >= FREQ_W'(100)) b = FBIN_W'(1);
        else                        b = FBIN_W'(0);
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- design/nearest_site_distance_binner_top.sv -----
// Load request: written into the site table at acceptance; loads run back to back.
// Query request: the search reads both end sites, then bisects; a position outside the end
// sites, and an empty table, skip the bisection.
// Throughput: one query at a time, the next taken in the cycle after the result enters the output
// register, later while the output stalls.
// Reset (synchronous, active low) clears control state and entry_count, not the site table.
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_site_distance_binner_top_defines.svh"

module nearest_site_distance_binner_top
    import nsdb_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COUNT_W-1:0] i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_opcode,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [FREQ_W-1:0]  i_allele_freq_milli,
    input  wire logic               i_on_platform_a,
    input  wire logic               i_on_platform_b,
    input  wire logic               i_coin,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [POS_W-1:0]        o_distance,
    output logic [BIN_W-1:0]        o_bin_number,
    output logic                    o_table_empty
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // Configuration: the entry count. Write it only while the block is idle; a query
    // samples it at acceptance.
    logic [COUNT_W-1:0] r_entry_count;
    logic [CW-1:0]      w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    // Clamp a count above the table depth to the depth.
    assign w_count = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : CW'(r_entry_count);

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [POS_W-1:0]  w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    logic [POS_W-1:0]  w_mem_rdata;
    t_search_res       w_res;
    logic              w_res_ready;

    // Site table: one write port for loads, one registered read port for the search.
    nsdb_site_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Binary search sequencer: reads both ends, then, for a position between them, halves the bracket each cycle.
    nsdb_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_search (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_count             (w_count),
        .i_req_valid         (i_in_valid),
        .o_req_stall         (o_in_stall),
        .i_opcode            (i_opcode),
        .i_entry_index       (i_entry_index),
        .i_position          (i_position),
        .i_allele_freq_milli (i_allele_freq_milli),
        .i_on_platform_a     (i_on_platform_a),
        .i_on_platform_b     (i_on_platform_b),
        .i_coin              (i_coin),
        .o_mem_we            (w_mem_we),
        .o_mem_waddr         (w_mem_waddr),
        .o_mem_wdata         (w_mem_wdata),
        .o_mem_raddr         (w_mem_raddr),
        .i_mem_rdata         (w_mem_rdata),
        .o_res               (w_res),
        .i_res_ready         (w_res_ready)
    );

    // Bin the distance and hold the result until the consumer takes it.
    nsdb_binner u_binner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (w_res),
        .o_res_ready   (w_res_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_distance    (o_distance),
        .o_bin_number  (o_bin_number),
        .o_table_empty (o_table_empty)
    );

    // An accepted query keeps the input side stalled on the next cycle.
    `NSDB_ASSERT(a_query_busy,
        (i_in_valid && !o_in_stall && i_opcode == OP_QUERY) |=> o_in_stall)
    // An empty-table result carries zero distance and zero bin.
    `NSDB_ASSERT(a_empty_zero,
        (o_out_valid && o_table_empty) |-> (o_distance == '0 && o_bin_number == '0))
    // The combined bin never leaves its range.
    `NSDB_ASSERT(a_bin_range,
        o_out_valid |-> (o_bin_number <= BIN_W'(269)))
    // A load request never starts a search.
    `NSDB_ASSERT(a_load_idle,
        (i_in_valid && !o_in_stall && i_opcode == OP_LOAD) |=> !o_in_stall)

endmodule

`default_nettype wire

// ----- design/nsdb_site_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsdb_site_mem
    import nsdb_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [POS_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [POS_W-1:0] o_rdata
);

    logic [POS_W-1:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/nsdb_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsdb_search
    import nsdb_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int unsigned AW = $clog2(TABLE_DEPTH),
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CW-1:0]     i_count,
    input  wire logic              i_req_valid,
    output logic                   o_req_stall,
    input  wire logic              i_opcode,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [FREQ_W-1:0] i_allele_freq_milli,
    input  wire logic              i_on_platform_a,
    input  wire logic              i_on_platform_b,
    input  wire logic              i_coin,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [POS_W-1:0]       o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  wire logic [POS_W-1:0]  i_mem_rdata,
    output t_search_res            o_res,
    input  wire logic              i_res_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RLO  = 3'd1;
    localparam logic [2:0] S_RHI  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [POS_W-1:0]  r_vlo, n_vlo, r_vhi, n_vhi;
    logic [POS_W-1:0]  r_pos, n_pos, r_dist, n_dist;
    logic [FBIN_W-1:0] r_fbin, n_fbin;
    logic              r_plat, n_plat, r_empty, n_empty;

    logic              w_accept;
    logic [AW:0]       w_sum;
    logic [AW-1:0]     w_mid;
    logic              w_more;
    logic [POS_W-1:0]  w_dlo, w_dhi;

    assign o_req_stall = (r_state != S_IDLE);
    assign w_accept    = i_req_valid && !o_req_stall;

    // Load requests go straight into the table; out-of-range slots are dropped.
    assign o_mem_we    = w_accept && (i_opcode == OP_LOAD)
                         && (32'(i_entry_index) < 32'(TABLE_DEPTH));
    assign o_mem_waddr = AW'(i_entry_index);
    assign o_mem_wdata = i_position;

    assign w_sum = {1'b0, n_lo} + {1'b0, n_hi};
    assign w_mid = w_sum[AW:1];
    assign w_more = (({1'b0, n_lo} + (AW+1)'(1)) < {1'b0, n_hi});
    assign w_dlo = r_pos - r_vlo;
    assign w_dhi = r_vhi - r_pos;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_vlo   = r_vlo;
        n_vhi   = r_vhi;
        n_pos   = r_pos;
        n_dist  = r_dist;
        n_fbin  = r_fbin;
        n_plat  = r_plat;
        n_empty = r_empty;
        o_mem_raddr = r_mid;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_QUERY)) begin
                    n_pos  = i_position;
                    n_fbin = freq_bin(i_allele_freq_milli);
                    if (i_on_platform_a && !i_on_platform_b) begin
                        n_plat = 1'b0;
                    end else if (!i_on_platform_a && i_on_platform_b) begin
                        n_plat = 1'b1;
                    end else begin
                        n_plat = i_coin;
                    end
                    n_lo = '0;
                    n_hi = AW'(i_count - CW'(1));
                    if (i_count == '0) begin
                        n_empty = 1'b1;
                        n_dist  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_empty = 1'b0;
                        n_state = S_RLO;
                    end
                end
            end
            S_RLO: begin
                o_mem_raddr = r_lo;
                n_state     = S_RHI;
            end
            S_RHI: begin
                o_mem_raddr = r_hi;
                n_vlo       = i_mem_rdata;
                n_state     = S_CHK;
            end
            S_CHK: begin
                n_vhi = i_mem_rdata;
                if (r_pos < r_vlo) begin
                    n_dist  = r_vlo - r_pos;
                    n_state = S_DONE;
                end else if (r_pos >= i_mem_rdata) begin
                    n_dist  = r_pos - i_mem_rdata;
                    n_state = S_DONE;
                end else if (w_more) begin
                    o_mem_raddr = w_mid;
                    n_mid       = w_mid;
                    n_state     = S_SRCH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SRCH: begin
                // Read data is the entry at r_mid; narrow and issue the next probe.
                if (r_pos < i_mem_rdata) begin
                    n_hi  = r_mid;
                    n_vhi = i_mem_rdata;
                end else begin
                    n_lo  = r_mid;
                    n_vlo = i_mem_rdata;
                end
                o_mem_raddr = w_mid;
                n_mid       = w_mid;
                if (!w_more) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Tie goes to the lower site.
                n_dist  = (w_dlo <= w_dhi) ? w_dlo : w_dhi;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_vlo   <= n_vlo;
        r_vhi   <= n_vhi;
        r_pos   <= n_pos;
        r_dist  <= n_dist;
        r_fbin  <= n_fbin;
        r_plat  <= n_plat;
        r_empty <= n_empty;
    end

    always_comb begin
        o_res.valid     = (r_state == S_DONE);
        o_res.empty     = r_empty;
        o_res.near_dist = r_dist;
        o_res.fbin      = r_fbin;
        o_res.plat      = r_plat;
    end

endmodule

`default_nettype wire

// ----- design/nsdb_binner.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsdb_binner
    import nsdb_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_search_res  i_res,
    output logic              o_res_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [POS_W-1:0]  o_distance,
    output logic [BIN_W-1:0]  o_bin_number,
    output logic              o_table_empty
);

    logic              r_valid;
    logic [POS_W-1:0]  r_dist;
    logic [BIN_W-1:0]  r_bin;
    logic              r_empty;
    logic [DBIN_W-1:0] w_dbin;
    logic [BIN_W-1:0]  w_bin;

    // Thresholds ascend, so the count of those exceeded is the distance bin.
    always_comb begin
        w_dbin = '0;
        for (int k = 0; k < NUM_THRESH; k++) begin
            w_dbin = w_dbin + DBIN_W'(i_res.near_dist > DIST_THRESH[k]);
        end
    end

    assign w_bin = i_res.empty ? '0
                 : BIN_W'(w_dbin)
                   + BIN_W'(i_res.fbin) * BIN_W'(DIST_BIN_SPAN)
                   + (i_res.plat ? BIN_W'(PLAT_SPAN) : BIN_W'(0));

    assign o_res_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res.valid) begin
            r_dist  <= i_res.near_dist;
            r_bin   <= w_bin;
            r_empty <= i_res.empty;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_distance    = r_dist;
    assign o_bin_number  = r_bin;
    assign o_table_empty = r_empty;

endmodule

`default_nettype wire
